// ===== rtl/core/fr_pkg.sv =====
`default_nettype none
package fr_pkg;

  // Fraction bits of the vector and index inputs
  localparam int FRAC_BITS = 12;

  // Internal angle quantities are Q30
  localparam int Q_BITS = 30;
  localparam int ROOT_W = Q_BITS + 1;
  localparam int RAD_W  = 2 * Q_BITS + 1;
  localparam int SQ_W   = 2 * ROOT_W;
  localparam int DVD_W  = 2 * ROOT_W;
  localparam int DVS_W  = 32;

  localparam int ETA_W  = (FRAC_BITS + 1 > 16) ? FRAC_BITS + 1 : 16;
  localparam int P_W    = ETA_W + ROOT_W;
  localparam int S_W    = P_W + 1;
  localparam int SH_W   = $clog2(S_W - DVS_W + 2);

  localparam int C_SHR  = (2 * FRAC_BITS > Q_BITS) ? 2 * FRAC_BITS - Q_BITS : 0;
  localparam int C_SHL  = (2 * FRAC_BITS > Q_BITS) ? 0 : Q_BITS - 2 * FRAC_BITS;

  localparam int RES_W  = 17;
  localparam int RND_SH = 2 * Q_BITS - (RES_W - 1) + 1;
  localparam int SUM_W  = SQ_W + 1;

  localparam logic [SQ_W-1:0]  ONE_SQ  = SQ_W'(1) << (2 * Q_BITS);
  localparam logic [ETA_W-1:0] ETA_ONE = ETA_W'(1) << FRAC_BITS;
  localparam logic [RES_W-1:0] RES_ONE = RES_W'(1) << (RES_W - 1);

  typedef struct packed {
    logic signed [15:0] incident_x;
    logic signed [15:0] incident_y;
    logic signed [15:0] incident_z;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic [15:0]        refr_index;
  } fr_in_t;

  typedef struct packed {
    logic [RES_W-1:0] reflectance;
    logic             total_internal;
  } fr_out_t;

  // Per-item data carried beside the arithmetic through the long units
  typedef struct packed {
    logic [ROOT_W-1:0] c;
    logic [ETA_W-1:0]  eta_i;
    logic [ETA_W-1:0]  eta_t;
    logic              tir;
    logic              spec;
  } fr_side_t;

endpackage
`default_nettype wire

// ===== rtl/core/fr_front.sv =====
`default_nettype none
module fr_front import fr_pkg::*; (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           en,
  input  wire logic           in_valid,
  input  wire fr_in_t         in_data,
  output logic                out_valid,
  output logic [RAD_W-1:0]    radicand,
  output fr_side_t            side
);

  localparam logic signed [41:0] ONE2 = 42'(64'sd1 << (2 * FRAC_BITS));

  logic              v1, v2, v3;
  logic signed [31:0] p0, p1, p2;
  logic [ETA_W-1:0]  eta1;
  fr_side_t          side2, side3;
  logic [SQ_W-1:0]   c2;

  logic signed [33:0] dot;
  logic signed [41:0] dotw, dotc;
  logic [41:0]        mag;
  logic               leaving;
  fr_side_t           side_next;

  always_comb begin
    dot  = 34'(p0) + 34'(p1) + 34'(p2);
    dotw = 42'(dot);
    if (dotw > ONE2) begin
      dotc = ONE2;
    end else if (dotw < -ONE2) begin
      dotc = -ONE2;
    end else begin
      dotc = dotw;
    end
    leaving = dotc > 42'sd0;
    mag = dotc[41] ? 42'(-dotc) : 42'(dotc);
    side_next.c     = ROOT_W'((mag >> C_SHR) << C_SHL);
    side_next.eta_i = leaving ? eta1 : ETA_ONE;
    side_next.eta_t = leaving ? ETA_ONE : eta1;
    side_next.tir   = 1'b0;
    side_next.spec  = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p0 <= 32'(in_data.incident_x) * 32'(in_data.normal_x);
      p1 <= 32'(in_data.incident_y) * 32'(in_data.normal_y);
      p2 <= 32'(in_data.incident_z) * 32'(in_data.normal_z);
      // zero index counts as one LSB
      eta1 <= (in_data.refr_index == 16'd0) ? ETA_W'(1) : ETA_W'(in_data.refr_index);
      side2 <= side_next;
      c2 <= side2.c * side2.c;
      side3 <= side2;
      radicand <= RAD_W'(ONE_SQ - c2);
      side <= side3;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/fr_sqrt.sv =====
`default_nettype none
module fr_sqrt import fr_pkg::*; (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire logic          in_valid,
  input  wire logic [RAD_W-1:0] radicand,
  input  wire fr_side_t      side_in,
  output logic               out_valid,
  output logic [ROOT_W-1:0]  root,
  output fr_side_t           side_out
);

  localparam int T_W = SQ_W + 1;

  logic [ROOT_W-1:0] valid_r;
  logic [RAD_W-1:0]  rem_r  [ROOT_W];
  logic [ROOT_W-1:0] root_r [ROOT_W];
  fr_side_t          side_r [ROOT_W];

  // One root bit per stage, most significant first
  for (genvar i = 0; i < ROOT_W; i++) begin : g_stage
    localparam int B = ROOT_W - 1 - i;
    logic              v_in;
    logic [RAD_W-1:0]  rem_in;
    logic [ROOT_W-1:0] root_in;
    fr_side_t          side_i;
    logic [T_W-1:0]    trial;
    logic              ge;

    if (i == 0) begin : g_first
      assign v_in    = in_valid;
      assign rem_in  = radicand;
      assign root_in = '0;
      assign side_i  = side_in;
    end else begin : g_next
      assign v_in    = valid_r[i-1];
      assign rem_in  = rem_r[i-1];
      assign root_in = root_r[i-1];
      assign side_i  = side_r[i-1];
    end

    assign trial = (T_W'(root_in) << (B + 1)) | (T_W'(1) << (2 * B));
    assign ge    = T_W'(rem_in) >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        valid_r[i] <= 1'b0;
      end else if (en) begin
        valid_r[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i]  <= ge ? RAD_W'(T_W'(rem_in) - trial) : rem_in;
        root_r[i] <= ge ? (root_in | (ROOT_W'(1) << B)) : root_in;
        side_r[i] <= side_i;
      end
    end
  end

  assign out_valid = valid_r[ROOT_W-1];
  assign root      = root_r[ROOT_W-1];
  assign side_out  = side_r[ROOT_W-1];

endmodule
`default_nettype wire

// ===== rtl/core/fr_div.sv =====
`default_nettype none
module fr_div import fr_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             en,
  input  wire logic             in_valid,
  input  wire logic [DVD_W-1:0] dividend,
  input  wire logic [DVS_W-1:0] divisor,
  input  wire fr_side_t         side_in,
  output logic                  out_valid,
  output logic [ROOT_W-1:0]     quotient,
  output fr_side_t              side_out
);

  localparam int W = DVD_W + 1;

  logic [ROOT_W-1:0] valid_r;
  logic [DVD_W-1:0]  rem_r [ROOT_W];
  logic [DVS_W-1:0]  dvs_r [ROOT_W];
  logic [ROOT_W-1:0] q_r   [ROOT_W];
  fr_side_t          side_r [ROOT_W];

  // Restoring division, one quotient bit per stage
  for (genvar i = 0; i < ROOT_W; i++) begin : g_stage
    localparam int B = ROOT_W - 1 - i;
    logic              v_in;
    logic [DVD_W-1:0]  rem_in;
    logic [DVS_W-1:0]  dvs_in;
    logic [ROOT_W-1:0] q_in;
    fr_side_t          side_i;
    logic [W-1:0]      sub;
    logic              ge;

    if (i == 0) begin : g_first
      assign v_in   = in_valid;
      assign rem_in = dividend;
      assign dvs_in = divisor;
      assign q_in   = '0;
      assign side_i = side_in;
    end else begin : g_next
      assign v_in   = valid_r[i-1];
      assign rem_in = rem_r[i-1];
      assign dvs_in = dvs_r[i-1];
      assign q_in   = q_r[i-1];
      assign side_i = side_r[i-1];
    end

    assign sub = W'(dvs_in) << B;
    assign ge  = W'(rem_in) >= sub;

    always_ff @(posedge clk) begin
      if (rst) begin
        valid_r[i] <= 1'b0;
      end else if (en) begin
        valid_r[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i]  <= ge ? DVD_W'(W'(rem_in) - sub) : rem_in;
        q_r[i]    <= ge ? (q_in | (ROOT_W'(1) << B)) : q_in;
        dvs_r[i]  <= dvs_in;
        side_r[i] <= side_i;
      end
    end
  end

  assign out_valid = valid_r[ROOT_W-1];
  assign quotient  = q_r[ROOT_W-1];
  assign side_out  = side_r[ROOT_W-1];

endmodule
`default_nettype wire

// ===== rtl/core/fr_coef.sv =====
`default_nettype none
module fr_coef import fr_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire logic              in_valid,
  input  wire logic [ROOT_W-1:0] cos_t,
  input  wire fr_side_t          side_in,
  output logic                   out_valid,
  output logic [DVS_W-1:0]       num_s,
  output logic [DVS_W-1:0]       den_s,
  output logic [DVS_W-1:0]       num_p,
  output logic [DVS_W-1:0]       den_p,
  output fr_side_t               side_out
);

  logic           v1, v2;
  logic [P_W-1:0] a1, a2, b1, b2;
  fr_side_t       side1, side2;
  fr_side_t       side1_mark;
  logic [S_W-1:0] d_s, d_p, n_s, n_p;
  logic [SH_W-1:0] sh_s, sh_p;

  function automatic logic [SH_W-1:0] norm_shift(input logic [S_W-1:0] d);
    logic [SH_W-1:0] s;
    s = '0;
    for (int i = DVS_W; i < S_W; i++) begin
      if (d[i]) begin
        s = SH_W'(i - DVS_W + 1);
      end
    end
    return s;
  endfunction

  assign sh_s = norm_shift(d_s);
  assign sh_p = norm_shift(d_p);

  // flag a zero denominator beside the item
  always_comb begin
    side1_mark      = side1;
    side1_mark.spec = (S_W'(a1) + S_W'(a2) == '0) || (S_W'(b1) + S_W'(b2) == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1 <= side_in.eta_t * side_in.c;
      a2 <= side_in.eta_i * cos_t;
      b1 <= side_in.eta_i * side_in.c;
      b2 <= side_in.eta_t * cos_t;
      side1 <= side_in;

      d_s <= S_W'(a1) + S_W'(a2);
      d_p <= S_W'(b1) + S_W'(b2);
      n_s <= (a1 >= a2) ? S_W'(a1 - a2) : S_W'(a2 - a1);
      n_p <= (b1 >= b2) ? S_W'(b1 - b2) : S_W'(b2 - b1);
      side2 <= side1_mark;

      // shift numerator and denominator together until the denominator fits
      num_s <= DVS_W'(n_s >> sh_s);
      den_s <= DVS_W'(d_s >> sh_s);
      num_p <= DVS_W'(n_p >> sh_p);
      den_p <= DVS_W'(d_p >> sh_p);
      side_out <= side2;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/fresnel_reflectance_core.sv =====
`default_nettype none
// Throughput: one item per cycle while the output queue has room; four chains of
// 31 one-bit stages (two square roots, two dividers) set the depth, and a two-entry
// output queue decouples stalls.
// Reset (rst, synchronous, active high) clears every valid bit and empties the
// output queue; datapath registers are not reset.
module fresnel_reflectance_core import fr_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    item_valid,
  output logic         item_ready,
  input  wire fr_in_t  item,
  output logic         result_valid,
  input  wire logic    result_ready,
  output fr_out_t      result
);

  // Pipeline advances whenever the output queue has room for one more result.
  logic en;

  // Front end: dot product, clamp, index swap, 1 - cos^2
  logic             fe_valid;
  logic [RAD_W-1:0] fe_rad;
  fr_side_t         fe_side;

  // sin_i = sqrt(1 - cos^2)
  logic              s1_valid;
  logic [ROOT_W-1:0] sin_i;
  fr_side_t          s1_side;

  // eta_i * sin_i, ready for the divide by eta_t
  logic              m_valid;
  logic [P_W-1:0]    m_num;
  logic [ETA_W-1:0]  m_dvs;
  fr_side_t          m_side;

  logic              d1_valid;
  logic [ROOT_W-1:0] d1_q;
  fr_side_t          d1_side;
  fr_side_t          d1_mark;

  // sin_t^2 and 1 - sin_t^2
  logic              g1_valid, g2_valid;
  logic [SQ_W-1:0]   g1_sq;
  fr_side_t          g1_side, g2_side;
  logic [RAD_W-1:0]  g2_rad;

  logic              s2_valid;
  logic [ROOT_W-1:0] cos_t;
  fr_side_t          s2_side;

  logic              cf_valid;
  logic [DVS_W-1:0]  num_s, den_s, num_p, den_p;
  fr_side_t          cf_side;

  logic              rs_valid, rp_valid;
  logic [ROOT_W-1:0] rs, rp;
  fr_side_t          rs_side, rp_side;

  // rs^2, rp^2
  logic              f_valid;
  logic [SQ_W-1:0]   sq_s, sq_p;
  fr_side_t          f_side;

  logic [SUM_W-1:0]  sum;
  logic [SUM_W-1:0]  mean;
  fr_out_t           res_next;

  // Output queue
  fr_out_t    q_mem [2];
  logic       q_wr, q_rd;
  logic [1:0] q_cnt;
  logic       push, pop;

  assign en         = (q_cnt != 2'd2);
  assign item_ready = en;

  fr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (item_valid),
    .in_data   (item),
    .out_valid (fe_valid),
    .radicand  (fe_rad),
    .side      (fe_side)
  );

  fr_sqrt u_sqrt_sin_i (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (fe_valid),
    .radicand  (fe_rad),
    .side_in   (fe_side),
    .out_valid (s1_valid),
    .root      (sin_i),
    .side_out  (s1_side)
  );

  // quotient bit for 1.0 set means sin_t >= 1: total internal reflection
  always_comb begin
    d1_mark     = d1_side;
    d1_mark.tir = d1_q[Q_BITS];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid  <= 1'b0;
      g1_valid <= 1'b0;
      g2_valid <= 1'b0;
      f_valid  <= 1'b0;
    end else if (en) begin
      m_valid  <= s1_valid;
      g1_valid <= d1_valid;
      g2_valid <= g1_valid;
      f_valid  <= rs_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_num  <= s1_side.eta_i * sin_i;
      m_dvs  <= s1_side.eta_t;
      m_side <= s1_side;

      g1_sq   <= SQ_W'(d1_q[Q_BITS-1:0]) * SQ_W'(d1_q[Q_BITS-1:0]);
      g1_side <= d1_mark;

      g2_rad  <= g1_side.tir ? '0 : RAD_W'(ONE_SQ - g1_sq);
      g2_side <= g1_side;

      sq_s   <= rs * rs;
      sq_p   <= rp * rp;
      f_side <= rs_side;
    end
  end

  fr_div u_div_sin_t (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (m_valid),
    .dividend  (DVD_W'(m_num)),
    .divisor   (DVS_W'(m_dvs)),
    .side_in   (m_side),
    .out_valid (d1_valid),
    .quotient  (d1_q),
    .side_out  (d1_side)
  );

  fr_sqrt u_sqrt_cos_t (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (g2_valid),
    .radicand  (g2_rad),
    .side_in   (g2_side),
    .out_valid (s2_valid),
    .root      (cos_t),
    .side_out  (s2_side)
  );

  fr_coef u_coef (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s2_valid),
    .cos_t     (cos_t),
    .side_in   (s2_side),
    .out_valid (cf_valid),
    .num_s     (num_s),
    .den_s     (den_s),
    .num_p     (num_p),
    .den_p     (den_p),
    .side_out  (cf_side)
  );

  fr_div u_div_rs (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (cf_valid),
    .dividend  (DVD_W'(num_s) << Q_BITS),
    .divisor   (den_s),
    .side_in   (cf_side),
    .out_valid (rs_valid),
    .quotient  (rs),
    .side_out  (rs_side)
  );

  // rp lane runs in lockstep with rs; its sideband copy only feeds a check
  fr_div u_div_rp (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (cf_valid),
    .dividend  (DVD_W'(num_p) << Q_BITS),
    .divisor   (den_p),
    .side_in   (cf_side),
    .out_valid (rp_valid),
    .quotient  (rp),
    .side_out  (rp_side)
  );

  // Mean of squares, round half up to Q1.16, saturate; TIR and degenerate
  // denominators force full reflectance.
  always_comb begin
    sum  = SUM_W'(sq_s) + SUM_W'(sq_p) + (SUM_W'(1) << (RND_SH - 1));
    mean = sum >> RND_SH;
    res_next.total_internal = f_side.tir;
    if (f_side.tir || f_side.spec || mean > SUM_W'(RES_ONE)) begin
      res_next.reflectance = RES_ONE;
    end else begin
      res_next.reflectance = RES_W'(mean);
    end
  end

  assign push = en && f_valid;
  assign pop  = result_valid && result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_wr  <= 1'b0;
      q_rd  <= 1'b0;
      q_cnt <= 2'd0;
    end else begin
      if (push) begin
        q_wr <= ~q_wr;
      end
      if (pop) begin
        q_rd <= ~q_rd;
      end
      q_cnt <= q_cnt + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[q_wr] <= res_next;
    end
  end

  assign result_valid = (q_cnt != 2'd0);
  assign result       = q_mem[q_rd];

  // The queue never holds more than two results.
  assert property (@(posedge clk) disable iff (rst) q_cnt != 2'd3)
    else $error("output queue overflow");

  // A stalled final stage keeps its item.
  assert property (@(posedge clk) disable iff (rst) (!en && f_valid) |=> f_valid)
    else $error("result dropped during stall");

  // Reflectance never exceeds 1.0, and total internal reflection reports exactly 1.0.
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.reflectance <= RES_ONE) &&
                     (!result.total_internal || result.reflectance == RES_ONE))
    else $error("reflectance out of range");

  // The pipeline stalls only while both queue entries are occupied.
  assert property (@(posedge clk) disable iff (rst) !item_ready |-> (result_valid && q_cnt == 2'd2))
    else $error("stall without full queue");

  // The two ratio lanes stay in step.
  assert property (@(posedge clk) disable iff (rst)
    (rs_valid == rp_valid) && (!rs_valid || rp_side == rs_side))
    else $error("ratio lanes out of step");

endmodule
`default_nettype wire

// ===== tb/sv/fresnel_reflectance_core_tb.sv =====
`timescale 1ns / 1ps
module fresnel_reflectance_core_tb import fr_pkg::*; ();

  logic    clk;
  logic    rst;
  logic    item_valid;
  logic    item_ready;
  fr_in_t  item;
  logic    result_valid;
  logic    result_ready;
  fr_out_t result;

  // Expected reflectance results, oldest first
  fr_out_t reflect_q[$];
  int      err_count;
  int      quiet_cycles;
  // Clear to hold both sides busy with no idling
  bit      idle_en;

  localparam int QUIET_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 200;

  fresnel_reflectance_core i_dut (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .item        (item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result      (result)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Integer square root, floor, by the bit-pair method
  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Amplitude ratio num/den in Q30; narrow den below 2^32 first
  function automatic longint unsigned amp_ratio(longint unsigned num, longint unsigned den);
    while (den >= (64'd1 << 32)) begin
      num = num >> 1;
      den = den >> 1;
    end
    return (num << Q_BITS) / den;
  endfunction

  // Unpolarized reflectance of one ray hit
  function automatic fr_out_t fresnel_predict(fr_in_t x);
    longint          dot;
    longint          one2;
    longint unsigned c, eta_i, eta_t, sin_i, sin_t, cos_t;
    longint unsigned a1, a2, b1, b2, den_s, den_p, rs, rp, r;
    logic            leaving;
    fr_out_t         o;
    dot = longint'(x.incident_x) * longint'(x.normal_x)
        + longint'(x.incident_y) * longint'(x.normal_y)
        + longint'(x.incident_z) * longint'(x.normal_z);
    one2 = longint'(1) << (2 * FRAC_BITS);
    if (dot > one2) dot = one2;
    if (dot < -one2) dot = -one2;
    leaving = dot > 0;
    c = (dot < 0) ? -dot : dot;
    c = (c >> C_SHR) << C_SHL;
    eta_i = 64'd1 << FRAC_BITS;
    eta_t = (x.refr_index == 0) ? 64'd1 : 64'(x.refr_index);
    // Ray leaving the object: swap the two indices
    if (leaving) begin
      eta_t = eta_i;
      eta_i = (x.refr_index == 0) ? 64'd1 : 64'(x.refr_index);
    end
    sin_i = root_floor((64'd1 << 60) - c * c);
    sin_t = eta_i * sin_i / eta_t;
    o.total_internal = 1'b0;
    if (sin_t >= (64'd1 << Q_BITS)) begin
      o.reflectance = RES_ONE;
      o.total_internal = 1'b1;
      return o;
    end
    cos_t = root_floor((64'd1 << 60) - sin_t * sin_t);
    a1 = eta_t * c;
    a2 = eta_i * cos_t;
    b1 = eta_i * c;
    b2 = eta_t * cos_t;
    den_s = a1 + a2;
    den_p = b1 + b2;
    if (den_s == 0 || den_p == 0) begin
      o.reflectance = RES_ONE;
      return o;
    end
    rs = amp_ratio((a1 >= a2) ? a1 - a2 : a2 - a1, den_s);
    rp = amp_ratio((b1 >= b2) ? b1 - b2 : b2 - b1, den_p);
    r = (rs * rs + rp * rp + (64'd1 << 44)) >> 45;
    if (r > 64'(RES_ONE)) r = 64'(RES_ONE);
    o.reflectance = r[RES_W-1:0];
    return o;
  endfunction

  function automatic fr_in_t make_ray(int ix, int iy, int iz, int nx, int ny, int nz,
                                      int eta);
    fr_in_t x;
    x.incident_x = 16'(ix);
    x.incident_y = 16'(iy);
    x.incident_z = 16'(iz);
    x.normal_x   = 16'(nx);
    x.normal_y   = 16'(ny);
    x.normal_z   = 16'(nz);
    x.refr_index = 16'(eta);
    return x;
  endfunction

  function automatic int pick_comp(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  // Mostly plausible hits with vector components within +/-2365; rest is raw noise
  function automatic fr_in_t random_ray();
    fr_in_t x;
    if ($urandom_range(0, 99) < 70) begin
      x = make_ray(pick_comp(2365), pick_comp(2365), pick_comp(2365),
                   pick_comp(2365), pick_comp(2365), pick_comp(2365),
                   ($urandom_range(0, 9) < 8) ? $urandom_range(2048, 12288)
                                              : $urandom_range(1, 65535));
    end else begin
      x.incident_x = 16'($urandom);
      x.incident_y = 16'($urandom);
      x.incident_z = 16'($urandom);
      x.normal_x   = 16'($urandom);
      x.normal_y   = 16'($urandom);
      x.normal_z   = 16'($urandom);
      x.refr_index = 16'($urandom_range(1, 65535));
    end
    return x;
  endfunction

  // Present one item and hold it until the transfer
  task automatic send_ray(fr_in_t x);
    while (idle_en && $urandom_range(0, 99) < 14) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= x;
    do @(posedge clk); while (!item_ready);
    reflect_q = {reflect_q, fresnel_predict(x)};
  endtask

  task automatic test_directed();
    // Normal incidence entering and leaving glass
    send_ray(make_ray(0, 0, -4096, 0, 0, 4096, 6144));
    send_ray(make_ray(0, 0, 4096, 0, 0, 4096, 6144));
    // Matched index: no reflection
    send_ray(make_ray(2896, 0, -2896, 0, 0, 4096, 4096));
    // Grazing exit from a dense medium: total internal reflection
    send_ray(make_ray(4000, 0, 800, 0, 0, 4096, 6144));
    send_ray(make_ray(2896, 0, 2896, 0, 0, 4096, 65535));
    // Grazing entry into a dense medium: no TIR
    send_ray(make_ray(4000, 0, -800, 0, 0, 4096, 6144));
    // Cosine exactly zero counts as entering
    send_ray(make_ray(4096, 0, 0, 0, 0, 4096, 6144));
    send_ray(make_ray(4096, 0, 0, 0, 0, 4096, 2048));
    // Zero and smallest index
    send_ray(make_ray(0, 2896, -2896, 0, 0, 4096, 0));
    send_ray(make_ray(0, 2896, 2896, 0, 0, 4096, 0));
    send_ray(make_ray(0, 2896, -2896, 0, 0, 4096, 1));
    send_ray(make_ray(0, 2896, 2896, 0, 0, 4096, 1));
    // Largest index
    send_ray(make_ray(1000, -1000, -3800, 0, 0, 4096, 65535));
    // Field extremes: dot clamps to +1 and -1
    send_ray(make_ray(-32768, -32768, -32768, -32768, -32768, -32768, 65535));
    send_ray(make_ray(32767, 32767, 32767, -32768, -32768, -32768, 6144));
    send_ray(make_ray(32767, -32768, 32767, 32767, -32768, 32767, 1));
    // Non-unit vectors, short and long: the dot product serves as the cosine
    send_ray(make_ray(100, 200, -300, 400, -500, 600, 5000));
    send_ray(make_ray(-1, 0, 0, 1, 0, 0, 4096));
    send_ray(make_ray(0, 0, 0, 0, 0, 0, 6144));
    send_ray(make_ray(5000, 0, 0, 5000, 0, 0, 3000));
  endtask

  task automatic test_random_steady();
    idle_en = 1'b0;
    repeat (300) send_ray(random_ray());
    idle_en = 1'b1;
  endtask

  task automatic test_random_idle();
    repeat (1100) send_ray(random_ray());
  endtask

  // Check each result transfer and randomly drop result_ready while idling is enabled
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        if (reflect_q.size() == 0) begin
          $error("unexpected result: reflectance %0d total_internal %0b",
                 result.reflectance, result.total_internal);
          err_count++;
        end else begin
          if (result.reflectance !== reflect_q[0].reflectance) begin
            $error("reflectance: expected %0d, got %0d",
                   reflect_q[0].reflectance, result.reflectance);
            err_count++;
          end
          if (result.total_internal !== reflect_q[0].total_internal) begin
            $error("total_internal: expected %0b, got %0b",
                   reflect_q[0].total_internal, result.total_internal);
            err_count++;
          end
          void'(reflect_q.pop_front());
        end
      end
      result_ready <= !(idle_en && $urandom_range(0, 99) < 14);
    end
  end

  // Watchdog: end the run when nothing transfers for too long
  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("** fresnel_reflectance_core: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst          = 1'b1;
    item_valid   = 1'b0;
    item         = '0;
    result_ready = 1'b0;
    err_count    = 0;
    quiet_cycles = 0;
    idle_en      = 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_steady();
    test_random_idle();
    item_valid <= 1'b0;
    // Drain outstanding results, then watch for strays
    while (reflect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0 && reflect_q.size() == 0) begin
      $display("** fresnel_reflectance_core: PASSED **");
    end else begin
      $display("** fresnel_reflectance_core: FAILED **");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/fr_pkg.sv
rtl/core/fr_front.sv
rtl/core/fr_sqrt.sv
rtl/core/fr_div.sv
rtl/core/fr_coef.sv
rtl/core/fresnel_reflectance_core.sv
tb/sv/fresnel_reflectance_core_tb.sv
